// ----- src/odt_pkg.sv -----
package odt_pkg;

  localparam int CMD_W   = 2;
  localparam int ID_W    = 32;
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 31;
  localparam int FILL_W  = 32;
  localparam int CODE_W  = 3;
  localparam int STAT_W  = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PLACE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FILL   = 2'd2;

  // Result codes.
  localparam logic [CODE_W-1:0] RC_PLACED    = 3'd0;
  localparam logic [CODE_W-1:0] RC_CANCELLED = 3'd1;
  localparam logic [CODE_W-1:0] RC_NOT_FOUND = 3'd2;
  localparam logic [CODE_W-1:0] RC_CLOSED    = 3'd3;
  localparam logic [CODE_W-1:0] RC_IGNORED   = 3'd4;
  localparam logic [CODE_W-1:0] RC_PARTIAL   = 3'd5;
  localparam logic [CODE_W-1:0] RC_FILLED    = 3'd6;
  localparam logic [CODE_W-1:0] RC_FULL      = 3'd7;

  // Order status codes held in a slot.
  localparam logic [STAT_W-1:0] ST_NEW     = 2'd0;
  localparam logic [STAT_W-1:0] ST_PARTIAL = 2'd1;
  localparam logic [STAT_W-1:0] ST_FILLED  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ready;     // input channel may take an item
    logic clr_step;  // clear one slot of the table
    logic accept;    // an item is taken this cycle
    logic mem_rd;    // read the addressed slot
    logic exec;      // apply the command and load the result
  } odt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_valid;  // an item is offered
    logic clr_last;   // the clearing pass is at its last slot
    logic mod_done;   // the slot index is ready
    logic out_busy;   // the result register still holds an untaken item
  } odt_sts_t;

endpackage

// ----- src/odt_in_if.sv -----
interface odt_in_if;
  import odt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic                      side;
  logic [PRICE_W-1:0]        price_ticks;
  logic [QTY_W-1:0]          order_qty;
  logic [ID_W-1:0]           target_id;
  logic signed [FILL_W-1:0]  fill_qty;

  modport source (
    output valid, cmd, side, price_ticks, order_qty, target_id, fill_qty,
    input  ready
  );

  modport sink (
    input  valid, cmd, side, price_ticks, order_qty, target_id, fill_qty,
    output ready
  );

endinterface

// ----- src/odt_out_if.sv -----
interface odt_out_if;
  import odt_pkg::*;

  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  result_code;
  logic [ID_W-1:0]    assigned_id;
  logic [QTY_W-1:0]   filled_total;
  logic [QTY_W-1:0]   total_qty;

  modport source (
    output valid, result_code, assigned_id, filled_total, total_qty,
    input  ready
  );

  modport sink (
    input  valid, result_code, assigned_id, filled_total, total_qty,
    output ready
  );

endinterface

// ----- src/odt_mod.sv -----
module odt_mod #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [odt_pkg::ID_W-1:0]       dividend,
  output logic [$clog2(TABLE_DEPTH)-1:0] slot,
  output logic                           done
);
  import odt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

  generate
    if (IS_POW2) begin : g_mask
      // A power-of-two depth is a plain mask of the low bits.
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else if (start) begin
          done <= 1'b1;
        end
        if (start) begin
          slot <= dividend[AW-1:0];
        end
      end
    end else begin : g_recip
      // Other depths use a reciprocal multiply. The estimated quotient is at most one
      // short, so the first remainder is below twice the depth and one compare and
      // subtract finishes it. Done rises with the slot, after the product and remainder.
      localparam int              SH    = ID_W + AW - 1;
      localparam logic [ID_W-1:0] RECIP = ID_W'((64'd1 << SH) / 64'(TABLE_DEPTH));
      localparam logic [ID_W-1:0] DIVC  = ID_W'(TABLE_DEPTH);
      localparam logic [AW:0]     DIV   = (AW + 1)'(TABLE_DEPTH);

      logic [2*ID_W-1:0] prod;
      logic [ID_W-1:0]   x_hold;
      logic              stg1;
      logic              stg2;
      logic [ID_W-1:0]   quot;
      logic [ID_W-1:0]   qd;
      logic [ID_W-1:0]   rem_full;
      logic [AW:0]       rem_est;
      logic [AW:0]       rem_sub;

      always_comb begin
        quot     = ID_W'(prod >> SH);
        qd       = quot * DIVC;
        rem_full = x_hold - qd;
        rem_sub  = rem_est - DIV;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          stg1 <= 1'b0;
          stg2 <= 1'b0;
          done <= 1'b0;
        end else begin
          stg1 <= start;
          stg2 <= stg1;
          if (start) begin
            done <= 1'b0;
          end else if (stg2) begin
            done <= 1'b1;
          end
        end
        if (start) begin
          prod   <= (2*ID_W)'(dividend) * (2*ID_W)'(RECIP);
          x_hold <= dividend;
        end
        if (stg1) begin
          rem_est <= rem_full[AW:0];
        end
        if (stg2) begin
          slot <= (rem_est >= DIV) ? rem_sub[AW-1:0] : rem_est[AW-1:0];
        end
      end
    end
  endgenerate

endmodule

// ----- src/odt_ctrl.sv -----
module odt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  odt_pkg::odt_sts_t sts,
  output odt_pkg::odt_cmd_t cmd
);
  import odt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MODW,
    S_EXEC
  } state_t;

  state_t state;
  logic   ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ready <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (sts.clr_last) begin
            state <= S_IDLE;
            ready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (sts.req_valid) begin
            state <= S_MODW;
            ready <= 1'b0;
          end
        end
        S_MODW: begin
          if (sts.mod_done) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!sts.out_busy) begin
            state <= S_IDLE;
            ready <= 1'b1;
          end
        end
        default: begin
          state <= S_CLEAR;
          ready <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.ready    = ready;
    cmd.clr_step = (state == S_CLEAR);
    cmd.accept   = ready && sts.req_valid;
    cmd.mem_rd   = (state == S_MODW) && sts.mod_done;
    cmd.exec     = (state == S_EXEC) && !sts.out_busy;
  end

endmodule

// ----- src/odt_dp.sv -----
module odt_dp #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  odt_pkg::odt_cmd_t cmd,
  output odt_pkg::odt_sts_t sts,
  odt_in_if.sink            req,
  odt_out_if.source         rsp
);
  import odt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [QTY_W-1:0]   filled;
    logic [STAT_W-1:0]  status;
  } slot_t;

  // Captured item.
  logic [CMD_W-1:0]         cap_cmd;
  logic                     cap_side;
  logic [PRICE_W-1:0]       cap_price;
  logic [QTY_W-1:0]         cap_oqty;
  logic [ID_W-1:0]          cap_tid;
  logic signed [FILL_W-1:0] cap_fill;

  logic [ID_W-1:0] next_id;
  logic [ID_W-1:0] dividend;
  logic [AW-1:0]   slot;
  logic            mod_done;
  logic [AW-1:0]   clr_addr;

  slot_t mem [TABLE_DEPTH];
  slot_t rd_word;

  // Result register.
  logic              out_valid;
  logic [CODE_W-1:0] out_code;
  logic [ID_W-1:0]   out_id;
  logic [QTY_W-1:0]  out_filled;
  logic [QTY_W-1:0]  out_qty;

  // Execute stage.
  logic              present;
  logic              open_order;
  logic              fill_nonpos;
  logic [QTY_W-1:0]  fill_pos;
  logic [QTY_W-1:0]  remain;
  logic [QTY_W-1:0]  delta;
  logic [QTY_W-1:0]  new_filled;
  logic              wr_en;
  slot_t             wr_word;
  logic              id_adv;
  logic [CODE_W-1:0] res_code;
  logic [ID_W-1:0]   res_id;
  logic [QTY_W-1:0]  res_filled;
  logic [QTY_W-1:0]  res_qty;

  assign dividend = (req.cmd == CMD_PLACE) ? next_id : req.target_id;

  odt_mod #(.TABLE_DEPTH(TABLE_DEPTH)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.accept),
    .dividend (dividend),
    .slot     (slot),
    .done     (mod_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cap_cmd   <= req.cmd;
      cap_side  <= req.side;
      cap_price <= req.price_ticks;
      cap_oqty  <= req.order_qty;
      cap_tid   <= req.target_id;
      cap_fill  <= req.fill_qty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_addr] <= '0;
    end else if (cmd.exec && wr_en) begin
      mem[slot] <= wr_word;
    end
    if (cmd.mem_rd) begin
      rd_word <= mem[slot];
    end
  end

  always_comb begin
    present     = rd_word.valid && (rd_word.id == cap_tid);
    open_order  = rd_word.valid && (rd_word.status != ST_FILLED);
    fill_nonpos = (cap_fill == '0) || cap_fill[FILL_W-1];
    fill_pos    = cap_fill[QTY_W-1:0];
    remain      = (rd_word.qty >= rd_word.filled) ? rd_word.qty - rd_word.filled : '0;
    delta       = (fill_pos < remain) ? fill_pos : remain;
    new_filled  = rd_word.filled + delta;

    wr_en      = 1'b0;
    wr_word    = rd_word;
    id_adv     = 1'b0;
    res_code   = RC_NOT_FOUND;
    res_id     = cap_tid;
    res_filled = '0;
    res_qty    = '0;

    case (cap_cmd)
      CMD_PLACE: begin
        res_id = next_id;
        if (open_order) begin
          res_code = RC_FULL;
        end else begin
          wr_en          = 1'b1;
          wr_word.valid  = 1'b1;
          wr_word.id     = next_id;
          wr_word.side   = cap_side;
          wr_word.price  = cap_price;
          wr_word.qty    = cap_oqty;
          wr_word.filled = '0;
          wr_word.status = ST_NEW;
          id_adv         = 1'b1;
          res_code       = RC_PLACED;
          res_qty        = cap_oqty;
        end
      end
      CMD_CANCEL: begin
        if (present) begin
          wr_en         = 1'b1;
          wr_word.valid = 1'b0;
          res_code      = RC_CANCELLED;
          res_filled    = rd_word.filled;
          res_qty       = rd_word.qty;
        end
      end
      CMD_FILL: begin
        if (present) begin
          res_filled = rd_word.filled;
          res_qty    = rd_word.qty;
          if (rd_word.status == ST_FILLED) begin
            res_code = RC_CLOSED;
          end else if (fill_nonpos) begin
            res_code = RC_IGNORED;
          end else begin
            wr_en          = 1'b1;
            wr_word.filled = new_filled;
            res_filled     = new_filled;
            if (new_filled >= rd_word.qty) begin
              wr_word.status = ST_FILLED;
              res_code       = RC_FILLED;
            end else begin
              wr_word.status = ST_PARTIAL;
              res_code       = RC_PARTIAL;
            end
          end
        end
      end
      default: begin
        res_code = RC_NOT_FOUND;
      end
    endcase
  end

  // Ids run from 1 to all ones and then wrap back to 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_id <= ID_W'(1);
    end else if (cmd.exec && id_adv) begin
      next_id <= (next_id == '1) ? ID_W'(1) : next_id + ID_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.exec) begin
      out_code   <= res_code;
      out_id     <= res_id;
      out_filled <= res_filled;
      out_qty    <= res_qty;
    end
  end

  assign req.ready        = cmd.ready;
  assign rsp.valid        = out_valid;
  assign rsp.result_code  = out_code;
  assign rsp.assigned_id  = out_id;
  assign rsp.filled_total = out_filled;
  assign rsp.total_qty    = out_qty;

  always_comb begin
    sts.req_valid = req.valid;
    sts.clr_last  = (clr_addr == AW'(TABLE_DEPTH - 1));
    sts.mod_done  = mod_done;
    sts.out_busy  = out_valid && !rsp.ready;
  end

endmodule

// ----- src/order_fill_tracking_table.sv -----
// Slot lookup: when TABLE_DEPTH is a power of two the low id bits give the slot index, and
// otherwise a three-step reciprocal multiply gives it.
// Flow: one item at a time; the next item is taken only after the slot lookup and the
// single-port slot table read then written for the previous one; a waiting result adds its stall.
// Reset: synchronous, active high. The counter restarts at id 1, and a clearing pass over all
// TABLE_DEPTH slots then empties the table while the input channel is held not ready.
module order_fill_tracking_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  odt_in_if.sink    req,
  odt_out_if.source rsp
);
  import odt_pkg::*;

  // The controller sequences one item at a time: take it, find its slot, read the slot,
  // then apply the command and load the result register. The result register lets the
  // next item be taken while the previous result still waits on the output channel.
  odt_cmd_t cmd;
  odt_sts_t sts;

  odt_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // The datapath holds the slot table, the id counter, the remainder unit that maps an id
  // to its slot, and the result register.
  odt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp)
  );

  // Only one item is in flight, so taking an item closes the input for the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("input taken while an item is in flight");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !sts.out_busy)
    else $error("result register overwritten");

  // The table is read only once the slot index is ready.
  a_read_after_index: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_rd |-> sts.mod_done)
    else $error("table read before slot index");

  // A result appears only after a command was applied.
  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.exec))
    else $error("result without command");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

// Testbench for the order fill tracking table.
//
// Every command sent into the block is also applied to a private copy of the
// order book kept here. That copy yields the reply the block must return, and
// the reply is queued in the order the commands were accepted. A checker
// process compares each reply the block hands out, field by field, with the
// oldest queued one.
//
// The run goes through a directed set of corner cases, then a pass that drives
// the counter into a slot that still holds an open order, then random traffic
// under three idling patterns, and finally a long receiver hold-off that backs
// the block up into its input channel.
module testbench;
  import odt_pkg::*;

  localparam int DEPTH = 256;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 20;
  localparam int REPORT_MAX = 10;

  // The package names only the three real commands. The fourth code must be
  // ignored by the block, so it gets a name here.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic                     side;
    logic [PRICE_W-1:0]       price_ticks;
    logic [QTY_W-1:0]         order_qty;
    logic [ID_W-1:0]          target_id;
    logic signed [FILL_W-1:0] fill_qty;
  } order_cmd_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [ID_W-1:0]   id;
    logic [QTY_W-1:0]  filled;
    logic [QTY_W-1:0]  qty;
  } order_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  odt_in_if  req_if();
  odt_out_if rsp_if();

  order_fill_tracking_table #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // The private order book. Side and price never show up in a reply, so they
  // are not tracked.
  logic [ID_W-1:0]   next_id;
  logic              bk_valid  [DEPTH];
  logic [ID_W-1:0]   bk_id     [DEPTH];
  logic [QTY_W-1:0]  bk_qty    [DEPTH];
  logic [QTY_W-1:0]  bk_filled [DEPTH];
  logic [STAT_W-1:0] bk_status [DEPTH];

  order_reply_t due_replies[$];

  int error_count = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Idling knobs, in percent of cycles, and the hold-off request for the
  // receiver. The receiver process owns the hold-off count once it takes it.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold_req = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Every input of the block holds a known value from time zero.
  initial begin
    req_if.valid       = 1'b0;
    req_if.cmd         = CMD_PLACE;
    req_if.side        = 1'b0;
    req_if.price_ticks = '0;
    req_if.order_qty   = '0;
    req_if.target_id   = '0;
    req_if.fill_qty    = '0;
  end

  // The receiver drops ready at random, or for a whole stretch when a
  // hold-off has been asked for. The stretch is counted here, cycle by cycle.
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_req != 0) begin
        hold_left = recv_hold_req;
        recv_hold_req = 0;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // A hard stop in case the block stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               due_replies.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Applies one accepted command to the order book and returns the reply that
  // the block owes for it. The slot of an id is the id modulo the depth, and an
  // id counts as present only when its slot is valid and holds that very id.
  function automatic order_reply_t apply_order_cmd(input order_cmd_t c);
    order_reply_t r;
    int unsigned s;
    logic [QTY_W-1:0] rem;
    logic [QTY_W-1:0] delta;
    r.code   = RC_NOT_FOUND;
    r.id     = c.target_id;
    r.filled = '0;
    r.qty    = '0;
    case (c.cmd)
      CMD_PLACE: begin
        s = next_id % DEPTH;
        r.id = next_id;
        if (bk_valid[s] && bk_status[s] != ST_FILLED) begin
          // An open order still sits in the slot: nothing is stored and the
          // counter stays where it is.
          r.code = RC_FULL;
        end else begin
          bk_valid[s]  = 1'b1;
          bk_id[s]     = next_id;
          bk_qty[s]    = c.order_qty;
          bk_filled[s] = '0;
          bk_status[s] = ST_NEW;
          next_id = (next_id == '1) ? 1 : next_id + 1;
          r.code = RC_PLACED;
          r.qty  = c.order_qty;
        end
      end
      CMD_CANCEL: begin
        s = c.target_id % DEPTH;
        if (bk_valid[s] && bk_id[s] == c.target_id) begin
          bk_valid[s] = 1'b0;
          r.code   = RC_CANCELLED;
          r.filled = bk_filled[s];
          r.qty    = bk_qty[s];
        end
      end
      CMD_FILL: begin
        s = c.target_id % DEPTH;
        if (bk_valid[s] && bk_id[s] == c.target_id) begin
          if (bk_status[s] == ST_FILLED) begin
            r.code = RC_CLOSED;
          end else if (c.fill_qty == '0 || c.fill_qty[FILL_W-1]) begin
            r.code = RC_IGNORED;
          end else begin
            // The fill is clamped to what is left, so the filled amount never
            // passes the ordered quantity.
            rem = bk_qty[s] - bk_filled[s];
            delta = (c.fill_qty < {1'b0, rem}) ? c.fill_qty[QTY_W-1:0] : rem;
            bk_filled[s] = bk_filled[s] + delta;
            if (bk_filled[s] >= bk_qty[s]) begin
              bk_status[s] = ST_FILLED;
              r.code = RC_FILLED;
            end else begin
              bk_status[s] = ST_PARTIAL;
              r.code = RC_PARTIAL;
            end
          end
          r.filled = bk_filled[s];
          r.qty    = bk_qty[s];
        end
      end
      default: begin
        // The unused command code changes nothing and reports not found.
      end
    endcase
    return r;
  endfunction

  // Replies are taken at the rising edge. The block's outputs come from its
  // own registers, so the values read here are those from before the edge.
  always @(posedge clk) begin
    order_reply_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (due_replies.size() == 0) begin
        error_count++;
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected reply: code %0d id %h filled %0d qty %0d",
                   rsp_if.result_code, rsp_if.assigned_id, rsp_if.filled_total,
                   rsp_if.total_qty);
        end
      end else begin
        want = due_replies.pop_front();
        if (rsp_if.result_code !== want.code || rsp_if.assigned_id !== want.id ||
            rsp_if.filled_total !== want.filled || rsp_if.total_qty !== want.qty) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("reply mismatch at cycle %0d (expected / actual):", cycle_count);
            $display("  code %0d / %0d  id %h / %h", want.code, rsp_if.result_code,
                     want.id, rsp_if.assigned_id);
            $display("  filled %0d / %0d  qty %0d / %0d", want.filled,
                     rsp_if.filled_total, want.qty, rsp_if.total_qty);
          end
        end
      end
    end
  end

  function automatic order_cmd_t make_cmd(input logic [CMD_W-1:0] cmd, input logic side,
                                          input logic [PRICE_W-1:0] price,
                                          input logic [QTY_W-1:0] qty,
                                          input logic [ID_W-1:0] tid,
                                          input logic [FILL_W-1:0] fill);
    order_cmd_t c;
    c.cmd         = cmd;
    c.side        = side;
    c.price_ticks = price;
    c.order_qty   = qty;
    c.target_id   = tid;
    c.fill_qty    = fill;
    return c;
  endfunction

  // Offers one item on the input channel, after a random number of idle
  // cycles, and waits until the block takes it. The reply it is owed is queued
  // at the edge where it is accepted. Valid stays high after the acceptance
  // until the next falling edge, where the next call or the drain sets it.
  task automatic send_order_cmd(input order_cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.cmd         <= c.cmd;
    req_if.side        <= c.side;
    req_if.price_ticks <= c.price_ticks;
    req_if.order_qty   <= c.order_qty;
    req_if.target_id   <= c.target_id;
    req_if.fill_qty    <= c.fill_qty;
    do @(posedge clk); while (!req_if.ready);
    due_replies.push_back(apply_order_cmd(c));
  endtask

  task automatic enter_order(input logic side, input logic [PRICE_W-1:0] price,
                             input logic [QTY_W-1:0] qty);
    send_order_cmd(make_cmd(CMD_PLACE, side, price, qty, $urandom, $urandom));
  endtask

  task automatic cancel_order(input logic [ID_W-1:0] tid);
    send_order_cmd(make_cmd(CMD_CANCEL, 1'($urandom), $urandom, QTY_W'($urandom), tid,
                            $urandom));
  endtask

  task automatic report_fill(input logic [ID_W-1:0] tid, input logic [FILL_W-1:0] fill);
    send_order_cmd(make_cmd(CMD_FILL, 1'($urandom), $urandom, QTY_W'($urandom), tid, fill));
  endtask

  // Lowers valid and waits until every queued reply has come back. Whatever is
  // still queued after the limit counts as missing.
  task automatic drain_replies();
    int waited;
    waited = 0;
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (due_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (due_replies.size() != 0) begin
      $display("%0d replies never arrived", due_replies.size());
      error_count += due_replies.size();
      due_replies.delete();
    end
  endtask

  // Draws the id of an order that is in the book, or failing that the id most
  // recently handed out.
  function automatic logic [ID_W-1:0] pick_live_id();
    int unsigned s;
    for (int k = 0; k < 8; k++) begin
      s = $urandom_range(DEPTH - 1);
      if (bk_valid[s]) begin
        return bk_id[s];
      end
    end
    return next_id - 1;
  endfunction

  function automatic logic [QTY_W-1:0] random_order_qty();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      return '0;
    end else if (pick < 80) begin
      return QTY_W'($urandom_range(60, 1));
    end
    return QTY_W'($urandom);
  endfunction

  function automatic logic [FILL_W-1:0] random_fill_qty();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      return '0;
    end else if (pick < 20) begin
      return $urandom | 32'h8000_0000;
    end else if (pick < 30) begin
      return $urandom;
    end
    return $urandom_range(40, 1);
  endfunction

  // Corner cases one by one: zero and largest quantities and prices, a fill on
  // an order of quantity zero, fills that are zero, negative or too large, a
  // fill on a closed order, cancel of an open and of a filled order, lookups
  // of absent ids and of an id that shares its slot with a live order, and the
  // unused command code.
  task automatic test_directed_cases();
    enter_order(1'b0, '0, '0);                  // id 1, quantity zero
    enter_order(1'b1, '1, '1);                  // id 2, largest fields
    enter_order(1'b0, 32'h5555_AAAA, 31'd100);  // id 3
    report_fill(32'd1, 32'd5);                  // zero quantity becomes filled
    report_fill(32'd1, 32'd5);                  // already closed
    report_fill(32'd3, 32'd0);                  // zero fill is ignored
    report_fill(32'd3, 32'h8000_0000);          // most negative fill is ignored
    report_fill(32'd3, 32'hFFFF_FFFF);          // minus one is ignored
    report_fill(32'd3, 32'd40);                 // partial
    report_fill(32'd3, 32'h7FFF_FFFF);          // clamped to the rest, filled
    report_fill(32'd3, 32'h8000_0000);          // closed wins over ignored
    report_fill(32'd2, 32'd1);                  // partial on the largest order
    report_fill(32'd2 + DEPTH, 32'd1);          // same slot, other id
    cancel_order(32'd2 + DEPTH);
    cancel_order(32'd2);                        // cancel of a partial order
    cancel_order(32'd2);                        // now absent
    report_fill(32'd2, 32'd1);
    cancel_order(32'd1);                        // cancel of a filled order
    cancel_order(32'hFFFF_FFFF);
    report_fill(32'h0000_0000, 32'd7);          // id zero is never handed out
    send_order_cmd(make_cmd(CMD_UNUSED, 1'b1, '1, '1, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
    send_order_cmd(make_cmd(CMD_UNUSED, 1'b0, '0, '0, 32'd3, '0));
    drain_replies();
  endtask

  // Places orders until the counter comes round to a slot that still holds an
  // open order, then frees that slot once by a fill and once by a cancel. A
  // filled order in the way is simply overwritten.
  task automatic test_table_full();
    for (int k = 0; k < DEPTH + 2; k++) begin
      enter_order(1'($urandom), $urandom, random_order_qty());
    end
    enter_order(1'b1, '1, '1);
    report_fill(next_id - DEPTH, 32'h7FFF_FFFF);
    enter_order(1'($urandom), $urandom, random_order_qty());
    enter_order(1'($urandom), $urandom, random_order_qty());
    cancel_order(next_id - DEPTH);
    enter_order(1'($urandom), $urandom, random_order_qty());
    drain_replies();
  endtask

  // Random traffic. Most commands address orders that are in the book, so
  // that fills accumulate and orders close; the rest is noise: random ids,
  // ids that only share a slot with a live order, and the unused command.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int count);
    int unsigned pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        enter_order(1'($urandom), $urandom, random_order_qty());
      end else if (pick < 75) begin
        report_fill(pick_live_id(), random_fill_qty());
      end else if (pick < 88) begin
        cancel_order(pick_live_id());
      end else if (pick < 92) begin
        send_order_cmd(make_cmd(CMD_W'($urandom_range(2, 1)), 1'($urandom), $urandom,
                                QTY_W'($urandom), $urandom, random_fill_qty()));
      end else if (pick < 96) begin
        send_order_cmd(make_cmd(CMD_W'($urandom_range(2, 1)), 1'($urandom), $urandom,
                                QTY_W'($urandom),
                                pick_live_id() + DEPTH * $urandom_range(3, 1),
                                random_fill_qty()));
      end else begin
        send_order_cmd(make_cmd(CMD_UNUSED, 1'($urandom), $urandom, QTY_W'($urandom),
                                $urandom, $urandom));
      end
    end
    drain_replies();
  endtask

  // The receiver stops taking replies for a long stretch while the sender
  // keeps offering items, so the block has to hold its input off.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_req = 400;
    test_random_traffic(0, 0, 40);
  endtask

  initial begin
    next_id = 1;
    for (int k = 0; k < DEPTH; k++) begin
      bk_valid[k] = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The block clears its table after reset with its input held not ready;
    // the first item simply waits for it.
    send_idle_pct = 24;
    recv_idle_pct = 81;
    test_directed_cases();
    test_table_full();
    test_random_traffic(24, 81, 260);
    test_random_traffic(81, 24, 260);
    test_random_traffic(0, 0, 250);
    test_backpressure();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
